FILE: src/dmxtx_pkg.sv
package dmxtx_pkg;

    // Defaults for the top-level parameters
    localparam int NUM_CHANNELS_DEF  = 512;
    localparam int TICKS_PER_BIT_DEF = 4;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int INDEX_W    = 10;
    localparam int VALUE_W    = 16;
    localparam int LEVEL_W    = 8;
    localparam int PHASE_W    = 3;
    localparam int RESULT_W   = 2;
    localparam int SLOT_W     = 10;
    localparam int ELAPSED_W  = 20;
    localparam int PTICK_W    = 16;
    localparam int SHIFT_W    = 11;
    localparam int BITPOS_W   = 4;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 20;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FILL  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SEND  = 2'd3;

    // Line phases
    localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_WAIT  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_BREAK = 3'd2;
    localparam logic [PHASE_W-1:0] PH_MAB   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DATA  = 3'd4;

    // Send request outcomes
    localparam logic [RESULT_W-1:0] RES_NONE    = 2'd0;
    localparam logic [RESULT_W-1:0] RES_STARTED = 2'd1;
    localparam logic [RESULT_W-1:0] RES_DROPPED = 2'd2;
    localparam logic [RESULT_W-1:0] RES_HELD    = 2'd3;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SLOTS      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BREAK      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MAB        = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PERIOD     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SKIP       = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_START_CODE = 3'd5;

    // Register reset values
    localparam logic [SLOT_W-1:0]    RST_SLOTS      = 10'd32;
    localparam logic [PTICK_W-1:0]   RST_BREAK      = 16'd176;
    localparam logic [PTICK_W-1:0]   RST_MAB        = 16'd12;
    localparam logic [ELAPSED_W-1:0] RST_PERIOD     = 20'd20000;
    localparam logic                 RST_SKIP       = 1'b0;
    localparam logic [LEVEL_W-1:0]   RST_START_CODE = 8'd0;

    // Last bit of a UART frame: start, 8 data, 2 stop
    localparam logic [BITPOS_W-1:0] FRAME_LAST_BIT = 4'd10;
    localparam logic [LEVEL_W-1:0]  LEVEL_MAX      = 8'd255;

    typedef struct packed {
        logic [CMD_W-1:0]   op;
        logic               wr_en;
        logic [INDEX_W-1:0] addr;
        logic [LEVEL_W-1:0] level;
    } item_t;

    typedef struct packed {
        logic [SLOT_W-1:0]    slots_to_send;
        logic [PTICK_W-1:0]   break_ticks;
        logic [PTICK_W-1:0]   mab_ticks;
        logic [ELAPSED_W-1:0] frame_period;
        logic                 skip_mode;
        logic [LEVEL_W-1:0]   start_code;
    } cfg_t;

endpackage

FILE: src/dmxtx_if.sv
interface dmxtx_req_if;
    logic                                valid;
    logic                                ready;
    logic [dmxtx_pkg::CMD_W-1:0]         cmd;
    logic [dmxtx_pkg::INDEX_W-1:0]       channel_index;
    logic signed [dmxtx_pkg::VALUE_W-1:0] value;

    modport source (output valid, cmd, channel_index, value, input ready);
    modport sink (input valid, cmd, channel_index, value, output ready);
endinterface

interface dmxtx_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             line_level;
    logic [dmxtx_pkg::PHASE_W-1:0]    phase;
    logic [dmxtx_pkg::RESULT_W-1:0]   request_result;
    logic [dmxtx_pkg::SLOT_W-1:0]     slot_number;

    modport source (output valid, line_level, phase, request_result, slot_number,
                    input ready);
    modport sink (input valid, line_level, phase, request_result, slot_number,
                  output ready);
endinterface

interface dmxtx_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [dmxtx_pkg::CFG_ADDR_W-1:0]  addr;
    logic [dmxtx_pkg::CFG_DATA_W-1:0]  wdata;

    modport source (output valid, addr, wdata, input ready);
    modport sink (input valid, addr, wdata, output ready);
endinterface

FILE: src/dmxtx_front.sv
module dmxtx_front #(
    parameter int NUM_CHANNELS = dmxtx_pkg::NUM_CHANNELS_DEF
) (
    dmxtx_req_if.sink          req,
    input  logic               clearing,
    output logic               push_valid,
    input  logic               push_ready,
    output dmxtx_pkg::item_t   push_item
);

    logic [dmxtx_pkg::LEVEL_W-1:0] level;

    // Clamp the signed level to 0..255
    always_comb
    begin
        if (req.value < 0)
        begin
            level = '0;
        end
        else if (req.value > $signed({8'd0, dmxtx_pkg::LEVEL_MAX}))
        begin
            level = dmxtx_pkg::LEVEL_MAX;
        end
        else
        begin
            level = req.value[dmxtx_pkg::LEVEL_W-1:0];
        end
    end

    // Classify the item; writes beyond the store become no-ops
    always_comb
    begin
        push_item.op    = req.cmd;
        push_item.wr_en = (req.cmd == dmxtx_pkg::CMD_WRITE) &&
                          (req.channel_index < dmxtx_pkg::INDEX_W'(NUM_CHANNELS));
        push_item.addr  = req.channel_index;
        push_item.level = level;
    end

    // No items while the store is being cleared after reset
    assign push_valid = req.valid && !clearing;
    assign req.ready  = push_ready && !clearing;

endmodule

FILE: src/dmxtx_queue.sv
module dmxtx_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  dmxtx_pkg::item_t   push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output dmxtx_pkg::item_t   pop_item
);

    dmxtx_pkg::item_t entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: src/dmxtx_back.sv
module dmxtx_back #(
    parameter int NUM_CHANNELS  = dmxtx_pkg::NUM_CHANNELS_DEF,
    parameter int TICKS_PER_BIT = dmxtx_pkg::TICKS_PER_BIT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dmxtx_pkg::cfg_t    cfg,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  dmxtx_pkg::item_t   pop_item,
    output logic               clearing,
    dmxtx_rsp_if.source        rsp
);

    localparam int CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int TPB_W = (TICKS_PER_BIT > 1) ? $clog2(TICKS_PER_BIT) : 1;

    localparam int SW = dmxtx_pkg::SHIFT_W;
    localparam int LW = dmxtx_pkg::LEVEL_W;

    // Sequencer states
    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_FILL = 2'd2;
    localparam logic [1:0] ST_RESP = 2'd3;

    // Channel store
    logic [LW-1:0] store_mem [NUM_CHANNELS];
    logic [LW-1:0] rdata_reg;
    logic          mem_we;
    logic [CH_AW-1:0] mem_waddr;
    logic [LW-1:0] mem_wdata;

    logic [1:0]                         st_reg, st_next;
    logic                               clearing_reg, clearing_next;
    logic [CH_AW-1:0]                   fill_cnt_reg, fill_cnt_next;
    logic [LW-1:0]                      fill_level_reg, fill_level_next;
    logic [dmxtx_pkg::ELAPSED_W-1:0]    elapsed_reg, elapsed_next;
    logic [dmxtx_pkg::PHASE_W-1:0]      phase_reg, phase_next;
    logic [dmxtx_pkg::PTICK_W-1:0]      ptick_reg, ptick_next;
    logic [dmxtx_pkg::SLOT_W-1:0]       slot_reg, slot_next;
    logic [SW-1:0]                      shifter_reg, shifter_next;
    logic [dmxtx_pkg::BITPOS_W-1:0]     bitpos_reg, bitpos_next;
    logic [TPB_W-1:0]                   btick_reg, btick_next;
    logic                               pending_reg, pending_next;
    logic [dmxtx_pkg::RESULT_W-1:0]     result_reg, result_next;

    logic                               out_valid_reg;
    logic                               out_line_reg;
    logic [dmxtx_pkg::PHASE_W-1:0]      out_phase_reg;
    logic [dmxtx_pkg::RESULT_W-1:0]     out_result_reg;
    logic [dmxtx_pkg::SLOT_W-1:0]       out_slot_reg;
    logic                               load_out;

    logic [dmxtx_pkg::ELAPSED_W-1:0]    el_inc;
    logic [dmxtx_pkg::ELAPSED_W-1:0]    el_cur;
    logic                               period_ok;
    logic [dmxtx_pkg::PTICK_W-1:0]      pt_inc;
    logic                               bt_last;
    logic                               frame_last;
    logic [dmxtx_pkg::SLOT_W-1:0]       slot_limit;
    logic                               slot_done;
    logic                               do_start;
    logic                               do_mab;
    logic                               do_data;
    logic                               do_end;

    assign pop_ready = (st_reg == ST_RUN);
    assign clearing  = clearing_reg;
    assign load_out  = (st_reg == ST_RESP) && (!out_valid_reg || rsp.ready);

    // Shared timing terms
    assign el_inc     = (elapsed_reg == '1) ? elapsed_reg
                                            : elapsed_reg + dmxtx_pkg::ELAPSED_W'(1);
    assign el_cur     = (st_reg == ST_RUN && pop_item.op == dmxtx_pkg::CMD_TICK)
                        ? el_inc : elapsed_reg;
    assign period_ok  = (el_cur >= cfg.frame_period);
    assign pt_inc     = ptick_reg + dmxtx_pkg::PTICK_W'(1);
    assign bt_last    = (btick_reg == TPB_W'(TICKS_PER_BIT - 1));
    assign frame_last = (bitpos_reg == dmxtx_pkg::FRAME_LAST_BIT);
    assign slot_limit = (cfg.slots_to_send > dmxtx_pkg::SLOT_W'(NUM_CHANNELS))
                        ? dmxtx_pkg::SLOT_W'(NUM_CHANNELS) : cfg.slots_to_send;
    assign slot_done  = (slot_reg >= slot_limit);

    // Item execution and transmitter state update
    always_comb
    begin
        st_next         = st_reg;
        clearing_next   = clearing_reg;
        fill_cnt_next   = fill_cnt_reg;
        fill_level_next = fill_level_reg;
        elapsed_next    = elapsed_reg;
        phase_next      = phase_reg;
        ptick_next      = ptick_reg;
        slot_next       = slot_reg;
        shifter_next    = shifter_reg;
        bitpos_next     = bitpos_reg;
        btick_next      = btick_reg;
        pending_next    = pending_reg;
        result_next     = result_reg;
        mem_we          = 1'b0;
        mem_waddr       = fill_cnt_reg;
        mem_wdata       = fill_level_reg;
        do_start        = 1'b0;
        do_mab          = 1'b0;
        do_data         = 1'b0;
        do_end          = 1'b0;

        unique case (st_reg)
            ST_RUN:
            begin
                if (pop_valid)
                begin
                    st_next     = ST_RESP;
                    result_next = dmxtx_pkg::RES_NONE;
                    case (pop_item.op)
                        dmxtx_pkg::CMD_TICK:
                        begin
                            elapsed_next = el_inc;
                            case (phase_reg)
                                dmxtx_pkg::PH_WAIT:
                                begin
                                    if (period_ok)
                                    begin
                                        do_start    = 1'b1;
                                        result_next = dmxtx_pkg::RES_STARTED;
                                    end
                                end
                                dmxtx_pkg::PH_BREAK:
                                begin
                                    ptick_next = pt_inc;
                                    if (pt_inc >= cfg.break_ticks)
                                    begin
                                        do_mab = 1'b1;
                                    end
                                end
                                dmxtx_pkg::PH_MAB:
                                begin
                                    ptick_next = pt_inc;
                                    if (pt_inc >= cfg.mab_ticks)
                                    begin
                                        do_data = 1'b1;
                                    end
                                end
                                dmxtx_pkg::PH_DATA:
                                begin
                                    if (bt_last)
                                    begin
                                        btick_next   = '0;
                                        shifter_next = {1'b1, shifter_reg[SW-1:1]};
                                        bitpos_next  = bitpos_reg +
                                                       dmxtx_pkg::BITPOS_W'(1);
                                        if (frame_last)
                                        begin
                                            if (slot_done)
                                            begin
                                                do_end = 1'b1;
                                            end
                                            else
                                            begin
                                                // next byte arrives from the store
                                                slot_next   = slot_reg +
                                                              dmxtx_pkg::SLOT_W'(1);
                                                bitpos_next = '0;
                                                st_next     = ST_LOAD;
                                            end
                                        end
                                    end
                                    else
                                    begin
                                        btick_next = btick_reg + TPB_W'(1);
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        dmxtx_pkg::CMD_WRITE:
                        begin
                            mem_we    = pop_item.wr_en;
                            mem_waddr = pop_item.addr[CH_AW-1:0];
                            mem_wdata = pop_item.level;
                        end
                        dmxtx_pkg::CMD_FILL:
                        begin
                            fill_level_next = pop_item.level;
                            fill_cnt_next   = '0;
                            st_next         = ST_FILL;
                        end
                        default:
                        begin
                            // send request
                            if (pending_reg)
                            begin
                                result_next = dmxtx_pkg::RES_DROPPED;
                            end
                            else if (phase_reg == dmxtx_pkg::PH_IDLE && period_ok)
                            begin
                                do_start    = 1'b1;
                                result_next = dmxtx_pkg::RES_STARTED;
                            end
                            else if (cfg.skip_mode)
                            begin
                                result_next = dmxtx_pkg::RES_DROPPED;
                            end
                            else
                            begin
                                pending_next = 1'b1;
                                result_next  = dmxtx_pkg::RES_HELD;
                                if (phase_reg == dmxtx_pkg::PH_IDLE)
                                begin
                                    phase_next = dmxtx_pkg::PH_WAIT;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_LOAD:
            begin
                shifter_next = {2'b11, rdata_reg, 1'b0};
                st_next      = ST_RESP;
            end
            ST_FILL:
            begin
                mem_we = 1'b1;
                if (fill_cnt_reg == CH_AW'(NUM_CHANNELS - 1))
                begin
                    clearing_next = 1'b0;
                    st_next       = clearing_reg ? ST_RUN : ST_RESP;
                end
                else
                begin
                    fill_cnt_next = fill_cnt_reg + CH_AW'(1);
                end
            end
            ST_RESP:
            begin
                if (load_out)
                begin
                    st_next = ST_RUN;
                end
            end
            default:
            begin
                st_next = ST_RUN;
            end
        endcase

        // End of frame: idle, or wait / restart for a held request
        if (do_end)
        begin
            phase_next   = dmxtx_pkg::PH_IDLE;
            slot_next    = '0;
            shifter_next = '1;
            bitpos_next  = '0;
            btick_next   = '0;
            if (pending_reg)
            begin
                phase_next = dmxtx_pkg::PH_WAIT;
                if (period_ok)
                begin
                    do_start    = 1'b1;
                    result_next = dmxtx_pkg::RES_STARTED;
                end
            end
        end

        // Frame start; zero-length phases fall through at once
        if (do_start)
        begin
            elapsed_next = '0;
            pending_next = 1'b0;
            phase_next   = dmxtx_pkg::PH_BREAK;
            ptick_next   = '0;
            slot_next    = '0;
            if (cfg.break_ticks == '0)
            begin
                do_mab = 1'b1;
            end
        end
        if (do_mab)
        begin
            phase_next = dmxtx_pkg::PH_MAB;
            ptick_next = '0;
            if (cfg.mab_ticks == '0)
            begin
                do_data = 1'b1;
            end
        end
        if (do_data)
        begin
            phase_next   = dmxtx_pkg::PH_DATA;
            slot_next    = '0;
            shifter_next = {2'b11, cfg.start_code, 1'b0};
            bitpos_next  = '0;
            btick_next   = '0;
        end
    end

    // Control and transmitter state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= ST_FILL;
            clearing_reg   <= 1'b1;
            fill_cnt_reg   <= '0;
            fill_level_reg <= '0;
            elapsed_reg    <= '1;
            phase_reg      <= dmxtx_pkg::PH_IDLE;
            ptick_reg      <= '0;
            slot_reg       <= '0;
            shifter_reg    <= '1;
            bitpos_reg     <= '0;
            btick_reg      <= '0;
            pending_reg    <= 1'b0;
            result_reg     <= dmxtx_pkg::RES_NONE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            st_reg         <= st_next;
            clearing_reg   <= clearing_next;
            fill_cnt_reg   <= fill_cnt_next;
            fill_level_reg <= fill_level_next;
            elapsed_reg    <= elapsed_next;
            phase_reg      <= phase_next;
            ptick_reg      <= ptick_next;
            slot_reg       <= slot_next;
            shifter_reg    <= shifter_next;
            bitpos_reg     <= bitpos_next;
            btick_reg      <= btick_next;
            pending_reg    <= pending_next;
            result_reg     <= result_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result register, taken from the state left by the item
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_result_reg <= result_reg;
            out_phase_reg  <= phase_reg;
            if (phase_reg == dmxtx_pkg::PH_BREAK)
            begin
                out_line_reg <= 1'b0;
            end
            else if (phase_reg == dmxtx_pkg::PH_DATA)
            begin
                out_line_reg <= shifter_reg[0];
            end
            else
            begin
                out_line_reg <= 1'b1;
            end
            out_slot_reg <= (phase_reg == dmxtx_pkg::PH_DATA) ? slot_reg : '0;
        end
    end

    // Store: one write port, one registered read port at the current slot
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= store_mem[slot_reg[CH_AW-1:0]];
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.line_level     = out_line_reg;
    assign rsp.phase          = out_phase_reg;
    assign rsp.request_result = out_result_reg;
    assign rsp.slot_number    = out_slot_reg;

endmodule

FILE: src/dmx512_frame_transmitter_unit.sv
// DMX512 transmitter. Each item on req is a one-microsecond tick, a channel write, a
// fill of all channels or a send request; each gives exactly one result on rsp with
// the line level, phase, request outcome and slot after that item. Items pass a
// two-entry queue into a sequencer that owns the channel store and takes the next item
// only after the result of the last is loaded for rsp. A tick that opens a new data slot
// passes a load state for the registered store read; a fill writes one store entry per
// cycle. After reset the store is cleared in a pass over all NUM_CHANNELS entries (512
// by default) during which req.ready stays low. Configuration writes are taken at any
// time (cfg.ready is tied high) and should be made only while the block is idle.
module dmx512_frame_transmitter_unit #(
    parameter int NUM_CHANNELS  = dmxtx_pkg::NUM_CHANNELS_DEF,
    parameter int TICKS_PER_BIT = dmxtx_pkg::TICKS_PER_BIT_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    dmxtx_req_if.sink      req,
    dmxtx_rsp_if.source    rsp,
    dmxtx_cfg_if.sink      cfg
);

    logic [dmxtx_pkg::SLOT_W-1:0]    slots_reg;
    logic [dmxtx_pkg::PTICK_W-1:0]   break_reg;
    logic [dmxtx_pkg::PTICK_W-1:0]   mab_reg;
    logic [dmxtx_pkg::ELAPSED_W-1:0] period_reg;
    logic                            skip_reg;
    logic [dmxtx_pkg::LEVEL_W-1:0]   start_code_reg;
    dmxtx_pkg::cfg_t                 cfg_bus;

    logic             clearing;
    logic             push_valid;
    logic             push_ready;
    dmxtx_pkg::item_t push_item;
    logic             pop_valid;
    logic             pop_ready;
    dmxtx_pkg::item_t pop_item;

    assign cfg.ready = 1'b1;

    // Configuration registers; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg      <= dmxtx_pkg::RST_SLOTS;
            break_reg      <= dmxtx_pkg::RST_BREAK;
            mab_reg        <= dmxtx_pkg::RST_MAB;
            period_reg     <= dmxtx_pkg::RST_PERIOD;
            skip_reg       <= dmxtx_pkg::RST_SKIP;
            start_code_reg <= dmxtx_pkg::RST_START_CODE;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.addr)
                dmxtx_pkg::REG_SLOTS:
                begin
                    slots_reg <= cfg.wdata[dmxtx_pkg::SLOT_W-1:0];
                end
                dmxtx_pkg::REG_BREAK:
                begin
                    break_reg <= cfg.wdata[dmxtx_pkg::PTICK_W-1:0];
                end
                dmxtx_pkg::REG_MAB:
                begin
                    mab_reg <= cfg.wdata[dmxtx_pkg::PTICK_W-1:0];
                end
                dmxtx_pkg::REG_PERIOD:
                begin
                    period_reg <= cfg.wdata[dmxtx_pkg::ELAPSED_W-1:0];
                end
                dmxtx_pkg::REG_SKIP:
                begin
                    skip_reg <= cfg.wdata[0];
                end
                dmxtx_pkg::REG_START_CODE:
                begin
                    start_code_reg <= cfg.wdata[dmxtx_pkg::LEVEL_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg_bus.slots_to_send = slots_reg;
        cfg_bus.break_ticks   = break_reg;
        cfg_bus.mab_ticks     = mab_reg;
        cfg_bus.frame_period  = period_reg;
        cfg_bus.skip_mode     = skip_reg;
        cfg_bus.start_code    = start_code_reg;
    end

    dmxtx_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .req        (req),
        .clearing   (clearing),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    dmxtx_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    dmxtx_back #(
        .NUM_CHANNELS  (NUM_CHANNELS),
        .TICKS_PER_BIT (TICKS_PER_BIT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_bus),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .clearing  (clearing),
        .rsp       (rsp)
    );

endmodule
